FILE: rtl/assert_macros.svh
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every rising clock edge outside reset
`define CHK_IMPL(label, clk_s, rst_n_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (!rst_n_s) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication checked outside reset
`define CHK_NEXT(label, clk_s, rst_n_s, ante, cons, msg) \
  label: assert property (@(posedge clk_s) disable iff (!rst_n_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/gtrc_pkg.sv
package gtrc_pkg;

  localparam int GlyphSlots   = 78;
  localparam int OverlaySide  = 32;
  localparam int OverlayTiles = 504;
  localparam int SlotW        = 7;
  localparam int SideW        = 5;
  localparam int AddrW        = 10;
  localparam int MapDepth     = 1024;
  localparam int TileW        = 9;
  localparam int RefW         = 11;
  localparam int CharW        = 21;
  localparam int CmdW         = 3;
  localparam int StatW        = 3;

  localparam logic [TileW-1:0] MissTile  = 9'd111;
  localparam logic [RefW-1:0]  RefsMax   = 11'd2047;

  typedef enum logic [CmdW-1:0] {
    CMD_MAP   = 3'd0,
    CMD_WRITE = 3'd1,
    CMD_READ  = 3'd2,
    CMD_CLEAR = 3'd3,
    CMD_MODE  = 3'd4
  } cmd_t;

  typedef enum logic [StatW-1:0] {
    ST_OK      = 3'd0,
    ST_RANGE   = 3'd1,
    ST_STALE   = 3'd2,
    ST_UNMAPPED = 3'd3,
    ST_MISS    = 3'd4
  } status_t;

  // controller to datapath commands
  typedef struct packed {
    logic             capture;     // latch input item
    logic             clr_slots;   // free every slot
    logic             set_mode;    // load glyph mode from item
    logic             scan_start;  // zero the slot pointer
    logic             scan_step;   // look at one slot, advance
    logic             map_rd;      // read overlay at item address
    logic             old_upd;     // release ref of old glyph
    logic             new_upd;     // add ref to new glyph and write map
    logic             claim;       // claim the free slot found
    logic             wipe_step;   // zero one map entry
    logic             wipe_start;
  } dp_cmd_t;

  // datapath to controller status
  typedef struct packed {
    cmd_t cmd;
    logic mode_on;
    logic wr_range_bad;
    logic rd_range_bad;
    logic scan_hit;
    logic scan_last;
    logic free_found;
    logic has_char;
    logic wipe_last;
    logic glyph_write;   // mode on and old != new
    logic new_unmapped;
  } dp_stat_t;

  function automatic logic glyph_slot_tile(input logic [TileW-1:0] t);
    return (t >= TileW'(1)) && (t <= TileW'(GlyphSlots));
  endfunction

endpackage

FILE: rtl/glyph_tile_refcount_table.sv
// channel | dir | tdata bits (low first)                                      | tuser
// in_     | in  | command[2:0] col[10:3] row[18:11] tile_value[28:19]        | -
//         |     | codepoint[49:29] font_has_char[50] mode_enable[51], pad 56  |
// out_    | out | tile_out[8:0] needs_load[9] status[12:10], pad to 16        | -
// one item at a time; a map command looks at one slot per scan cycle,
// a clear zeroes one overlay map entry per cycle
// reset clears mode and slot table at once, then every overlay map entry
// is zeroed before in_tready rises
// in_tready is low from acceptance until the result has been taken
module glyph_tile_refcount_table
  import gtrc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [55:0] in_tdata,   // command, col, row, tile_value, codepoint, font_has_char, mode_enable
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata   // tile_out, needs_load, status
);

  dp_cmd_t          dcmd;
  dp_stat_t         dstat;
  logic [TileW-1:0] map_q, tile_r;
  logic [SlotW-1:0] hit_slot, free_slot;
  logic             stale, load_r;
  logic [StatW-1:0] st_r;

  gtrc_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_i      (dcmd),
    .in_cmd     (in_tdata[2:0]),
    .in_col     (in_tdata[10:3]),
    .in_row     (in_tdata[18:11]),
    .in_val     (in_tdata[28:19]),
    .in_cp      (in_tdata[49:29]),
    .in_has     (in_tdata[50]),
    .in_en      (in_tdata[51]),
    .stat_o     (dstat),
    .map_q_o    (map_q),
    .hit_slot_o (hit_slot),
    .free_slot_o(free_slot),
    .old_stale_o(stale)
  );

  gtrc_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat_i     (dstat),
    .map_q_i    (map_q),
    .hit_slot_i (hit_slot),
    .free_slot_i(free_slot),
    .old_stale_i(stale),
    .cmd_o      (dcmd),
    .tile_r_o   (tile_r),
    .load_r_o   (load_r),
    .status_r_o (st_r)
  );

  assign out_tdata = {3'b000, st_r, load_r, tile_r};

endmodule

FILE: rtl/gtrc_datapath.sv
module gtrc_datapath
  import gtrc_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  dp_cmd_t             cmd_i,
  input  logic [CmdW-1:0]     in_cmd,
  input  logic [7:0]          in_col,
  input  logic [7:0]          in_row,
  input  logic [AddrW-1:0]    in_val,
  input  logic [CharW-1:0]    in_cp,
  input  logic                in_has,
  input  logic                in_en,
  output dp_stat_t            stat_o,
  output logic [TileW-1:0]    map_q_o,
  output logic [SlotW-1:0]    hit_slot_o,
  output logic [SlotW-1:0]    free_slot_o,
  output logic                old_stale_o
);

  logic [CmdW-1:0]  cmd_r;
  logic [7:0]       col_r, row_r;
  logic [AddrW-1:0] val_r;
  logic [CharW-1:0] cp_r;
  logic             has_r, en_r, mode_r;

  logic [GlyphSlots-1:0] valid_r;
  logic [RefW-1:0]  refs_mem [GlyphSlots];
  logic [CharW-1:0] char_mem [GlyphSlots];
  logic [RefW-1:0]  refs_old_q_r, refs_new_q_r;
  logic [CharW-1:0] char_q_r;

  logic [TileW-1:0] map_mem [MapDepth];
  logic [TileW-1:0] map_q_r;
  logic [AddrW-1:0] wipe_r;

  logic [SlotW-1:0] ptr_r, free_r, ptr_nxt;
  logic             free_ok_r, stale_r;

  logic [AddrW-1:0] addr;
  logic [TileW-1:0] new_t;
  logic [SlotW-1:0] old_s, new_s;
  logic             old_glyph, new_glyph;

  assign addr      = {col_r[SideW-1:0], row_r[SideW-1:0]};
  assign new_t     = val_r[TileW-1:0];
  assign old_s     = SlotW'(map_q_r - TileW'(1));
  assign new_s     = SlotW'(new_t - TileW'(1));
  assign old_glyph = glyph_slot_tile(map_q_r);
  assign new_glyph = glyph_slot_tile(new_t);

  // item capture
  always_ff @(posedge clk) begin
    if (cmd_i.capture) begin
      cmd_r <= in_cmd;
      col_r <= in_col;
      row_r <= in_row;
      val_r <= in_val;
      cp_r  <= in_cp;
      has_r <= in_has;
      en_r  <= in_en;
    end
  end

  // glyph mode
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b0;
    end else if (cmd_i.set_mode) begin
      mode_r <= en_r;
    end
  end

  // overlay memory, one port
  always_ff @(posedge clk) begin
    if (cmd_i.wipe_step) begin
      map_mem[wipe_r] <= '0;
    end else if (cmd_i.new_upd) begin
      map_mem[addr] <= new_t;
    end
    if (cmd_i.map_rd) begin
      map_q_r <= map_mem[addr];
    end
  end

  // wipe pointer, also swept once after reset
  always_ff @(posedge clk) begin
    if (!rst_n || cmd_i.wipe_start) begin
      wipe_r <= '0;
    end else if (cmd_i.wipe_step) begin
      wipe_r <= wipe_r + AddrW'(1);
    end
  end

  // slot pointer for the next cycle, used as the char read address
  always_comb begin
    ptr_nxt = ptr_r;
    if (cmd_i.scan_start) begin
      ptr_nxt = '0;
    end else if (cmd_i.scan_step) begin
      ptr_nxt = ptr_r + SlotW'(1);
    end
  end

  // scan pointer and first free slot
  always_ff @(posedge clk) begin
    if (cmd_i.scan_start) begin
      ptr_r     <= '0;
      free_ok_r <= 1'b0;
      free_r    <= '0;
    end else if (cmd_i.scan_step) begin
      ptr_r <= ptr_r + SlotW'(1);
      if (!valid_r[ptr_r] && !free_ok_r) begin
        free_ok_r <= 1'b1;
        free_r    <= ptr_r;
      end
    end
  end

  // slot valid flags
  always_ff @(posedge clk) begin
    if (!rst_n || cmd_i.clr_slots) begin
      valid_r <= '0;
    end else if (cmd_i.claim) begin
      valid_r[free_r] <= 1'b1;
    end else if (cmd_i.old_upd && old_glyph && valid_r[old_s] &&
                 (refs_old_q_r <= RefW'(1))) begin
      valid_r[old_s] <= 1'b0;
    end
  end

  // old glyph slot already free
  always_ff @(posedge clk) begin
    if (cmd_i.old_upd) begin
      stale_r <= old_glyph && !valid_r[old_s];
    end
  end

  // reference counts, one write and two registered reads a cycle
  always_ff @(posedge clk) begin
    if (cmd_i.claim) begin
      refs_mem[free_r] <= '0;
    end else if (cmd_i.old_upd && old_glyph && valid_r[old_s]) begin
      if (refs_old_q_r <= RefW'(1)) begin
        refs_mem[old_s] <= '0;
      end else begin
        refs_mem[old_s] <= refs_old_q_r - RefW'(1);
      end
    end else if (cmd_i.new_upd && stat_o.glyph_write && new_glyph) begin
      if (refs_new_q_r < RefsMax) begin
        refs_mem[new_s] <= refs_new_q_r + RefW'(1);
      end
    end
    refs_old_q_r <= refs_mem[old_s];
    refs_new_q_r <= refs_mem[new_s];
  end

  // slot codepoints, read one slot ahead of the scan
  always_ff @(posedge clk) begin
    if (cmd_i.claim) begin
      char_mem[free_r] <= cp_r;
    end
    char_q_r <= char_mem[ptr_nxt];
  end

  // status toward controller
  always_comb begin
    stat_o.cmd          = cmd_t'(cmd_r);
    stat_o.mode_on      = mode_r;
    stat_o.rd_range_bad = (col_r >= 8'(OverlaySide)) || (row_r >= 8'(OverlaySide));
    stat_o.wr_range_bad = stat_o.rd_range_bad || (val_r >= AddrW'(OverlayTiles));
    stat_o.scan_hit     = valid_r[ptr_r] && (char_q_r == cp_r);
    stat_o.scan_last    = (ptr_r == SlotW'(GlyphSlots - 1));
    stat_o.free_found   = free_ok_r || !valid_r[ptr_r];
    stat_o.has_char     = has_r;
    stat_o.wipe_last    = (wipe_r == AddrW'(MapDepth - 1));
    stat_o.glyph_write  = mode_r && (map_q_r != new_t);
    stat_o.new_unmapped = new_glyph && !valid_r[new_s];
  end

  assign map_q_o     = map_q_r;
  assign hit_slot_o  = ptr_r;
  assign free_slot_o = free_ok_r ? free_r : ptr_r;
  assign old_stale_o = stale_r;

endmodule

FILE: rtl/gtrc_ctrl.sv
module gtrc_ctrl
  import gtrc_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  output logic             out_tvalid,
  input  logic             out_tready,
  input  dp_stat_t         stat_i,
  input  logic [TileW-1:0] map_q_i,
  input  logic [SlotW-1:0] hit_slot_i,
  input  logic [SlotW-1:0] free_slot_i,
  input  logic             old_stale_i,
  output dp_cmd_t          cmd_o,
  output logic [TileW-1:0] tile_r_o,
  output logic             load_r_o,
  output logic [StatW-1:0] status_r_o
);

  typedef enum logic [10:0] {
    S_IDLE  = 11'b00000000001,
    S_DEC   = 11'b00000000010,
    S_SCAN  = 11'b00000000100,
    S_RD    = 11'b00000001000,
    S_WOLD  = 11'b00000010000,
    S_WREL  = 11'b00000100000,
    S_WNEW  = 11'b00001000000,
    S_RDOUT = 11'b00010000000,
    S_WIPE  = 11'b00100000000,
    S_OUT   = 11'b01000000000,
    S_INIT  = 11'b10000000000
  } state_t;

  state_t state_r, state_nxt;
  logic [TileW-1:0] tile_r, tile_nxt;
  logic             load_r, load_nxt;
  logic [StatW-1:0] st_r, st_nxt;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = (state_r == S_OUT);
  assign tile_r_o   = tile_r;
  assign load_r_o   = load_r;
  assign status_r_o = st_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
    end else begin
      state_r <= state_nxt;
    end
    tile_r <= tile_nxt;
    load_r <= load_nxt;
    st_r   <= st_nxt;
  end

  // sequencer
  always_comb begin
    state_nxt = state_r;
    tile_nxt  = tile_r;
    load_nxt  = load_r;
    st_nxt    = st_r;
    cmd_o     = '0;
    unique case (state_r)
      S_INIT: begin
        // overlay sweep after reset
        cmd_o.wipe_step = 1'b1;
        if (stat_i.wipe_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_tvalid) begin
          cmd_o.capture = 1'b1;
          state_nxt     = S_DEC;
        end
      end
      S_DEC: begin
        tile_nxt = '0;
        load_nxt = 1'b0;
        st_nxt   = status_t'(ST_OK);
        state_nxt = S_OUT;
        unique case (stat_i.cmd)
          CMD_MAP: begin
            if (!stat_i.mode_on) begin
              tile_nxt = MissTile;
              st_nxt   = ST_MISS;
            end else begin
              cmd_o.scan_start = 1'b1;
              state_nxt        = S_SCAN;
            end
          end
          CMD_WRITE: begin
            if (stat_i.wr_range_bad) begin
              st_nxt = ST_RANGE;
            end else begin
              cmd_o.map_rd = 1'b1;
              state_nxt    = S_WOLD;
            end
          end
          CMD_READ: begin
            if (stat_i.rd_range_bad) begin
              st_nxt = ST_RANGE;
            end else begin
              cmd_o.map_rd = 1'b1;
              state_nxt    = S_RDOUT;
            end
          end
          CMD_CLEAR: begin
            cmd_o.clr_slots  = 1'b1;
            cmd_o.wipe_start = 1'b1;
            state_nxt        = S_WIPE;
          end
          CMD_MODE: begin
            cmd_o.set_mode  = 1'b1;
            cmd_o.clr_slots = 1'b0;
            state_nxt       = S_RD;
          end
          default: st_nxt = ST_RANGE;
        endcase
      end
      S_RD: begin
        // mode command, after the mode is set: clear slots when enabling
        cmd_o.clr_slots = stat_i.mode_on;
        state_nxt       = S_OUT;
      end
      S_SCAN: begin
        if (stat_i.scan_hit) begin
          tile_nxt  = TileW'(hit_slot_i) + TileW'(1);
          state_nxt = S_OUT;
        end else if (stat_i.scan_last) begin
          if (stat_i.has_char && stat_i.free_found) begin
            cmd_o.scan_step = 1'b1;
            cmd_o.claim     = 1'b0;
            tile_nxt        = TileW'(free_slot_i) + TileW'(1);
            load_nxt        = 1'b1;
            state_nxt       = S_WNEW;
          end else begin
            tile_nxt  = MissTile;
            st_nxt    = ST_MISS;
            state_nxt = S_OUT;
          end
        end else begin
          cmd_o.scan_step = 1'b1;
        end
      end
      S_WOLD: begin
        // old tile is in, its reference count is being read
        state_nxt = S_WREL;
      end
      S_WREL: begin
        if (stat_i.glyph_write) begin
          cmd_o.old_upd = 1'b1;
        end
        state_nxt = S_WNEW;
      end
      S_WNEW: begin
        if (load_r) begin
          // finishing a map command: claim the slot
          cmd_o.claim = 1'b1;
          state_nxt   = S_OUT;
        end else begin
          st_nxt = (stat_i.glyph_write && old_stale_i) ? ST_STALE : ST_OK;
          if (stat_i.glyph_write && stat_i.new_unmapped) begin
            st_nxt = ST_UNMAPPED;
          end else begin
            cmd_o.new_upd = 1'b1;
          end
          state_nxt = S_OUT;
        end
      end
      S_RDOUT: begin
        tile_nxt  = map_q_i;
        state_nxt = S_OUT;
      end
      S_WIPE: begin
        cmd_o.wipe_step = 1'b1;
        if (stat_i.wipe_last) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (out_tready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

FILE: rtl/gtrc_checker.sv
`include "assert_macros.svh"

module gtrc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata
);

  `CHK_IMPL(a_no_overlap, clk, rst_n, out_tvalid, !in_tready, "input taken while result pending")
  `CHK_IMPL(a_status_code, clk, rst_n, out_tvalid, out_tdata[12:10] <= 3'd4, "bad status code")
  `CHK_IMPL(a_load_ok, clk, rst_n, out_tvalid && out_tdata[9], out_tdata[12:10] == 3'd0, "load with error")
  `CHK_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "result dropped")

endmodule

bind glyph_tile_refcount_table gtrc_checker u_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_tvalid (in_tvalid),
  .in_tready (in_tready),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata)
);

FILE: sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import gtrc_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [55:0] in_tdata;   // command, col, row, tile_value, codepoint, font_has_char, mode_enable
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;  // tile_out, needs_load, status

  glyph_tile_refcount_table uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  // highest field first so that tile lands in the low bits
  typedef struct packed {
    logic [2:0] status;
    logic       load;
    logic [8:0] tile;
  } tile_result_t;

  // shadow copy of the table
  logic        shadow_mode;
  logic [8:0]  shadow_map [MapDepth];
  logic        shadow_valid [GlyphSlots];
  logic [10:0] shadow_refs [GlyphSlots];
  logic [20:0] shadow_char [GlyphSlots];

  tile_result_t pending_results [$];
  int errors;
  int sent_count;
  int got_count;
  int map_count;
  int claim_count;
  int wipe_count;

  always begin
    clk = 1'b0; #4;
    clk = 1'b1; #4;
  end

  function automatic bit glyph_tile(input logic [9:0] t);
    return t >= 1 && t <= GlyphSlots;
  endfunction

  function automatic void free_slots();
    for (int s = 0; s < GlyphSlots; s++) begin
      shadow_valid[s] = 1'b0;
      shadow_refs[s] = '0;
      shadow_char[s] = '0;
    end
  endfunction

  // compute the result of one command and update the shadow state
  function automatic tile_result_t table_step(input logic [2:0] cmd, input logic [7:0] col,
      input logic [7:0] row, input logic [9:0] val, input logic [20:0] cp,
      input logic has, input logic en);
    tile_result_t r;
    int idx;
    int s;
    logic [9:0] old;
    r = '{tile: 9'd0, load: 1'b0, status: ST_OK};
    case (cmd)
      CMD_MAP: begin
        r.tile = MissTile; r.status = ST_MISS;
        if (shadow_mode) begin
          for (s = 0; s < GlyphSlots; s++)
            if (shadow_valid[s] && shadow_char[s] == cp) begin
              r = '{tile: 9'(s + 1), load: 1'b0, status: ST_OK};
              return r;
            end
          if (has)
            for (s = 0; s < GlyphSlots; s++)
              if (!shadow_valid[s]) begin
                shadow_valid[s] = 1'b1;
                shadow_refs[s] = '0;
                shadow_char[s] = cp;
                r = '{tile: 9'(s + 1), load: 1'b1, status: ST_OK};
                return r;
              end
        end
      end
      CMD_WRITE: begin
        if (col >= OverlaySide || row >= OverlaySide || val >= OverlayTiles) begin
          r.status = ST_RANGE;
          return r;
        end
        idx = col * OverlaySide + row;
        old = {1'b0, shadow_map[idx]};
        if (shadow_mode && old != val) begin
          if (glyph_tile(old)) begin
            s = old - 1;
            if (shadow_valid[s]) begin
              if (shadow_refs[s] <= 1) begin
                shadow_valid[s] = 1'b0;
                shadow_refs[s] = '0;
                shadow_char[s] = '0;
              end else
                shadow_refs[s] = shadow_refs[s] - 1;
            end else
              r.status = ST_STALE;
          end
          if (glyph_tile(val)) begin
            s = val - 1;
            if (!shadow_valid[s]) begin
              r.status = ST_UNMAPPED;
              return r;
            end
            if (shadow_refs[s] < RefsMax) shadow_refs[s] = shadow_refs[s] + 1;
          end
        end
        shadow_map[idx] = val[8:0];
      end
      CMD_READ: begin
        if (col >= OverlaySide || row >= OverlaySide) r.status = ST_RANGE;
        else r.tile = shadow_map[col * OverlaySide + row];
      end
      CMD_CLEAR: begin
        for (int i = 0; i < MapDepth; i++) shadow_map[i] = '0;
        free_slots();
      end
      CMD_MODE: begin
        if (en) free_slots();
        shadow_mode = en;
      end
      default: r.status = ST_RANGE;
    endcase
    return r;
  endfunction

  // random gap, mostly short with a few long ones
  task automatic idle_gap();
    int n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 2);
    if ($urandom_range(0, 3) == 0) n = 0;
    repeat (n) @(posedge clk);
  endtask

  // send one item and queue its expected result
  task automatic send_item(input logic [2:0] cmd, input logic [7:0] col, input logic [7:0] row,
      input logic [9:0] val, input logic [20:0] cp, input logic has, input logic en);
    // valid drops between items
    @(posedge clk);
    idle_gap();
    in_tdata <= {4'd0, en, has, cp, val, row, col, cmd};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    in_tvalid <= 1'b0;
    pending_results.insert(pending_results.size(),
                           table_step(cmd, col, row, val, cp, has, en));
    sent_count++;
    if (cmd == CMD_MAP) map_count++;
    if (cmd == CMD_CLEAR) wipe_count++;
  endtask

  task automatic drain();
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // result checker and receiver stalls
  always @(posedge clk) begin
    tile_result_t got;
    tile_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = tile_result_t'(out_tdata[12:0]);
      got_count++;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (want.load) claim_count++;
        if (got.tile !== want.tile) begin
          $display("%0t: tile_out expected %0d actual %0d", $time, want.tile, got.tile);
          errors++;
        end
        if (got.load !== want.load) begin
          $display("%0t: needs_load expected %0d actual %0d", $time, want.load, got.load);
          errors++;
        end
        if (got.status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
          errors++;
        end
      end
    end
    if (!rst_n) out_tready <= 1'b0;
    else if ($urandom_range(0, 29) == 0) out_tready <= 1'b0;
    else if ($urandom_range(0, 2) == 0) out_tready <= 1'b1;
  end

  task automatic test_directed();
    send_item(CMD_MAP, 0, 0, 0, 21'h41, 1, 0);          // map outside glyph mode
    send_item(CMD_READ, 255, 0, 0, 0, 0, 0);
    send_item(CMD_READ, 0, 255, 0, 0, 0, 0);
    send_item(CMD_WRITE, 31, 31, 503, 0, 0, 0);
    send_item(CMD_READ, 31, 31, 0, 0, 0, 0);
    send_item(CMD_WRITE, 0, 0, 504, 0, 0, 0);
    send_item(CMD_WRITE, 0, 0, 1023, 0, 0, 0);
    send_item(CMD_WRITE, 32, 0, 5, 0, 0, 0);
    send_item(CMD_WRITE, 3, 3, 5, 0, 0, 0);             // stale glyph later
    send_item(CMD_MODE, 0, 0, 0, 0, 0, 1);
    send_item(CMD_MAP, 0, 0, 0, 21'h1FFFFF, 1, 0);      // claim slot 0
    send_item(CMD_MAP, 0, 0, 0, 21'h1FFFFF, 0, 0);      // hit
    send_item(CMD_MAP, 0, 0, 0, 21'h0, 0, 0);           // font lacks it
    send_item(CMD_WRITE, 1, 1, 1, 0, 0, 0);
    send_item(CMD_WRITE, 1, 1, 1, 0, 0, 0);             // same tile again
    send_item(CMD_WRITE, 2, 2, 50, 0, 0, 0);            // unmapped glyph
    send_item(CMD_WRITE, 3, 3, 0, 0, 0, 0);             // old glyph stale
    send_item(CMD_WRITE, 1, 1, 0, 0, 0, 0);             // release, slot freed
    send_item(CMD_MAP, 0, 0, 0, 21'h10FFFF, 1, 0);
    send_item(7, 0, 0, 0, 0, 0, 0);
    send_item(5, 255, 255, 1023, 21'h1FFFFF, 1, 1);
    send_item(CMD_CLEAR, 0, 0, 0, 0, 0, 0);
    send_item(CMD_MODE, 0, 0, 0, 0, 0, 0);
    drain();
  endtask

  // fill every slot so that the table runs out
  task automatic test_table_full();
    send_item(CMD_MODE, 0, 0, 0, 0, 0, 1);
    for (int i = 0; i < GlyphSlots + 2; i++)
      send_item(CMD_MAP, 0, 0, 0, 21'(i + 100), 1, 0);
    send_item(CMD_MAP, 0, 0, 0, 21'(100 + GlyphSlots - 1), 1, 0);
    drain();
  endtask

  // random text-like traffic on a small window of the overlay
  task automatic test_random();
    logic [2:0] cmd;
    logic [7:0] col, row;
    logic [9:0] val;
    logic [20:0] cp;
    int k;
    send_item(CMD_MODE, 0, 0, 0, 0, 0, 1);
    for (int i = 0; i < 300; i++) begin
      k = $urandom_range(0, 99);
      col = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3));
      row = ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3));
      val = ($urandom_range(0, 3) == 0) ? 10'($urandom) : 10'($urandom_range(0, 12));
      cp = ($urandom_range(0, 4) == 0) ? 21'($urandom) : 21'($urandom_range(0, 15));
      if (k < 35) cmd = CMD_MAP;
      else if (k < 75) cmd = CMD_WRITE;
      else if (k < 92) cmd = CMD_READ;
      else if (k < 94) cmd = CMD_CLEAR;
      else if (k < 98) cmd = CMD_MODE;
      else cmd = 3'($urandom_range(5, 7));
      send_item(cmd, col, row, val, cp, ($urandom_range(0, 4) != 0),
                ($urandom_range(0, 3) != 0));
      if (i == 150) drain();
    end
    drain();
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    out_tready = 1'b0;
    errors = 0;
    sent_count = 0;
    got_count = 0;
    map_count = 0;
    claim_count = 0;
    wipe_count = 0;
    shadow_mode = 1'b0;
    for (int i = 0; i < MapDepth; i++) shadow_map[i] = '0;
    free_slots();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_table_full();
    test_random();
    $display("covered %0d items: %0d glyph maps, %0d slot claims, %0d overlay clears",
             sent_count, map_count, claim_count, wipe_count);
    $display("results checked: %0d", got_count);
    if (errors == 0 && pending_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("FAILURE");
    $finish;
  end

endmodule
